// ----- rtl/slug_pkg.sv -----
// ----------------------------------------------------------------------------
// slug_pkg
// Shared types, constants and lookup functions for the UTF-8 / Latin-1 slug
// transliterator.
// ----------------------------------------------------------------------------
package slug_pkg;

    localparam logic [7:0] LEAD_C2   = 8'hC2;
    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] SEP_RESET = 8'd45;   // '-'
    localparam logic [7:0] CASE_BIT  = 8'd32;

    // Folded symbol codes
    typedef enum logic [4:0] {
        SYM_NONE,
        SYM_A,
        SYM_E,
        SYM_I,
        SYM_O,
        SYM_U,
        SYM_N,
        SYM_C,
        SYM_P,
        SYM_Y,
        SYM_X,
        SYM_R,
        SYM_D,
        SYM_SS,
        SYM_AE,
        SYM_OE,
        SYM_UE
    } sym_code_t;

    // Up to two ASCII characters produced by one symbol
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
    } sym_t;

    // Latin-1 0xC0..0xFF, indexed by the low six bits
    function automatic sym_code_t upper_map(input logic [5:0] idx);
        sym_code_t r;
        case (idx)
            6'h00, 6'h01, 6'h02, 6'h03, 6'h05: r = SYM_A;
            6'h20, 6'h21, 6'h22, 6'h23, 6'h25: r = SYM_A;
            6'h04, 6'h06, 6'h24, 6'h26:        r = SYM_AE;
            6'h07, 6'h27:                      r = SYM_C;
            6'h08, 6'h09, 6'h0A, 6'h0B:        r = SYM_E;
            6'h28, 6'h29, 6'h2A, 6'h2B:        r = SYM_E;
            6'h0C, 6'h0D, 6'h0E, 6'h0F:        r = SYM_I;
            6'h2C, 6'h2D, 6'h2E, 6'h2F:        r = SYM_I;
            6'h10:                             r = SYM_D;
            6'h11, 6'h31:                      r = SYM_N;
            6'h12, 6'h13, 6'h14, 6'h15:        r = SYM_O;
            6'h30, 6'h32, 6'h33, 6'h34, 6'h35: r = SYM_O;
            6'h16, 6'h36:                      r = SYM_OE;
            6'h17:                             r = SYM_X;
            6'h19, 6'h1A, 6'h1B:               r = SYM_U;
            6'h39, 6'h3A, 6'h3B:               r = SYM_U;
            6'h1C, 6'h3C:                      r = SYM_UE;
            6'h1D, 6'h3D, 6'h3F:               r = SYM_Y;
            6'h1E, 6'h3E:                      r = SYM_P;
            6'h1F:                             r = SYM_SS;
            default:                           r = SYM_NONE;
        endcase
        return r;
    endfunction

    function automatic sym_code_t single_code(input logic [7:0] b);
        sym_code_t r;
        if (b >= 8'hC0) begin
            r = upper_map(b[5:0]);
        end
        else begin
            case (b)
                8'hA1:        r = SYM_I;
                8'hA2, 8'hA9: r = SYM_C;
                8'hA5:        r = SYM_Y;
                8'hAE:        r = SYM_R;
                8'hB5:        r = SYM_U;
                default:      r = SYM_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic sym_code_t pair_code(input logic [7:0] lead, input logic [7:0] second);
        sym_code_t r;
        r = SYM_NONE;
        if (lead == LEAD_C3) begin
            if (second[7:6] == 2'b10) begin
                if (second == 8'h98 || second == 8'hB8) r = SYM_O;
                else                                    r = upper_map(second[5:0]);
            end
        end
        else if (lead == LEAD_C2) begin
            case (second)
                8'hB5:        r = SYM_U;
                8'hA7, 8'hA2: r = SYM_C;
                8'hA5:        r = SYM_Y;
                8'hAE:        r = SYM_R;
                default:      r = SYM_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic sym_t sym_text(input sym_code_t code);
        sym_t r;
        r = '{len: 2'd1, c0: 8'h00, c1: 8'h00};
        case (code)
            SYM_A:   r.c0 = "a";
            SYM_E:   r.c0 = "e";
            SYM_I:   r.c0 = "i";
            SYM_O:   r.c0 = "o";
            SYM_U:   r.c0 = "u";
            SYM_N:   r.c0 = "n";
            SYM_C:   r.c0 = "c";
            SYM_P:   r.c0 = "p";
            SYM_Y:   r.c0 = "y";
            SYM_X:   r.c0 = "x";
            SYM_R:   r.c0 = "r";
            SYM_D:   r.c0 = "d";
            SYM_SS:  r = '{len: 2'd2, c0: "s", c1: "s"};
            SYM_AE:  r = '{len: 2'd2, c0: "a", c1: "e"};
            SYM_OE:  r = '{len: 2'd2, c0: "o", c1: "e"};
            SYM_UE:  r = '{len: 2'd2, c0: "u", c1: "e"};
            default: r.len = 2'd0;
        endcase
        return r;
    endfunction

    // One byte on its own: alphanumerics pass, capitals fold, rest via table
    function automatic sym_t single_sym(input logic [7:0] b);
        sym_t r;
        if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
            r = '{len: 2'd1, c0: b, c1: 8'h00};
        end
        else if (b >= "A" && b <= "Z") begin
            r = '{len: 2'd1, c0: b | CASE_BIT, c1: 8'h00};
        end
        else begin
            r = sym_text(single_code(b));
        end
        return r;
    endfunction

endpackage

// ----- rtl/utf8_latin1_slug_transliterator.sv -----
// ----------------------------------------------------------------------------
// utf8_latin1_slug_transliterator
// Streams a UTF-8 / Latin-1 string byte by byte into a lower-case ASCII slug.
// ----------------------------------------------------------------------------
// An input byte is taken into an input register, translated combinationally
// into up to four slug characters (owed separator, a flushed lead byte and
// the byte's own one or two letters) and loaded into a result buffer that
// drains one result per cycle while out_ready is high, through its single
// read port; the next byte is taken in the cycle the last result of the
// previous one leaves. Between input transfer and first result lie the
// input register and the result buffer. A 0xC2/0xC3 lead byte gives no
// result until the following byte, unless it is the last byte of the string.
// The separator register may only be written while the block is idle.
module utf8_latin1_slug_transliterator
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [7:0]              cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    last_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    byte_valid,
    output logic                    end_of_string,
    output logic                    last_of_run
);
    import slug_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      cnt;
        logic            owed;
        logic            seen;
    } acc_t;

    function automatic acc_t push_sym(input acc_t a, input sym_t s, input logic [7:0] sep);
        acc_t r;
        r = a;
        if (s.len != 2'd0) begin
            if (r.owed) begin
                r.chars[r.cnt[1:0]] = sep;
                r.cnt  = r.cnt + 3'd1;
                r.owed = 1'b0;
            end
            r.chars[r.cnt[1:0]] = s.c0;
            r.cnt = r.cnt + 3'd1;
            if (s.len == 2'd2) begin
                r.chars[r.cnt[1:0]] = s.c1;
                r.cnt = r.cnt + 3'd1;
            end
            r.seen = 1'b1;
        end
        else if (r.seen) begin
            r.owed = 1'b1;
        end
        return r;
    endfunction

    // configuration
    logic [7:0]      sep_reg;

    // input register
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            last_reg;

    // string state
    logic [7:0]      held_reg, held_next;
    logic            held_valid_reg, held_valid_next;
    logic            seen_reg, seen_next;
    logic            owed_reg, owed_next;

    // result buffer
    logic            buf_valid_reg;
    logic [3:0][7:0] buf_chars_reg;
    logic [1:0]      buf_last_idx_reg;
    logic [1:0]      buf_idx_reg;
    logic            buf_bare_reg;
    logic            buf_eos_reg;

    acc_t            acc;
    sym_code_t       pc;
    logic            consumed;
    logic            emit;
    logic            advance;
    logic            pop;
    logic            buf_free;

    // ---------------------------------------------------------------- translate
    always_comb begin
        acc             = '{chars: '0, cnt: 3'd0, owed: owed_reg, seen: seen_reg};
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        consumed        = 1'b0;
        pc              = SYM_NONE;

        if (held_valid_reg) begin
            held_valid_next = 1'b0;
            pc = pair_code(held_reg, in_byte_reg);
            if (pc != SYM_NONE) begin
                acc      = push_sym(acc, sym_text(pc), sep_reg);
                consumed = 1'b1;
            end
            else begin
                acc = push_sym(acc, single_sym(held_reg), sep_reg);
            end
        end

        if (!consumed) begin
            // a lead byte on the last byte is not held
            if (!last_reg && (in_byte_reg == LEAD_C2 || in_byte_reg == LEAD_C3)) begin
                held_next       = in_byte_reg;
                held_valid_next = 1'b1;
            end
            else begin
                acc = push_sym(acc, single_sym(in_byte_reg), sep_reg);
            end
        end

        seen_next = acc.seen;
        owed_next = acc.owed;
        if (last_reg) begin
            held_next       = 8'h00;
            held_valid_next = 1'b0;
            seen_next       = 1'b0;
            owed_next       = 1'b0;
        end

        emit = (acc.cnt != 3'd0) || last_reg;
    end

    // ---------------------------------------------------------------- handshake
    assign last_of_run = (buf_idx_reg == buf_last_idx_reg);
    assign pop         = buf_valid_reg && out_ready;
    assign buf_free    = !buf_valid_reg || (out_ready && last_of_run);
    assign advance     = in_valid_reg && buf_free;
    assign in_ready    = !in_valid_reg || buf_free;

    assign out_valid     = buf_valid_reg;
    assign out_byte      = buf_bare_reg ? 8'h00 : buf_chars_reg[buf_idx_reg];
    assign byte_valid    = !buf_bare_reg;
    assign end_of_string = buf_eos_reg && last_of_run;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg        <= SEP_RESET;
            in_valid_reg   <= 1'b0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            seen_reg       <= 1'b0;
            owed_reg       <= 1'b0;
            buf_valid_reg  <= 1'b0;
            buf_idx_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                sep_reg <= cfg_wdata;
            end

            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end

            if (advance)
            begin
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                seen_reg       <= seen_next;
                owed_reg       <= owed_next;
            end

            // a new run fills an empty buffer or replaces the one whose last result leaves this cycle
            if (advance && emit)
            begin
                buf_valid_reg <= 1'b1;
                buf_idx_reg   <= 2'd0;
            end
            else if (pop)
            begin
                if (last_of_run) buf_valid_reg <= 1'b0;
                else             buf_idx_reg   <= buf_idx_reg + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
            last_reg    <= last_byte;
        end

        if (advance && emit)
        begin
            buf_chars_reg    <= acc.chars;
            buf_bare_reg     <= (acc.cnt == 3'd0);
            buf_eos_reg      <= last_reg;
            buf_last_idx_reg <= (acc.cnt == 3'd0) ? 2'd0 : 2'(acc.cnt - 3'd1);
        end
    end

endmodule

// ----- rtl/slug_checker.sv -----
// ----------------------------------------------------------------------------
// slug_checker
// Port-level checks for the slug transliterator, bound to the top level.
// ----------------------------------------------------------------------------
module slug_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       end_of_string,
    input logic       last_of_run
);

    // end of string only ever closes the run of its input byte
    a_eos_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last_of_run)
        else $error("end_of_string without last_of_run");

    // a bare marker is the final result of the string and carries a zero byte
    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_string && last_of_run && out_byte == 8'h00)
        else $error("bare marker not at end of string");

    // input is only back-pressured while results are pending
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
                                    && $stable(end_of_string) && $stable(last_of_run))
        else $error("result changed while stalled");

endmodule

bind utf8_latin1_slug_transliterator slug_checker u_slug_checker (.*);

// ----- tb/utf8_latin1_slug_transliterator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin1_slug_transliterator_tb
// Streams directed and random byte strings through the slug transliterator
// under bursty input and a stalling output, predicts every output character
// per accepted byte and checks each output transfer in order.
// ----------------------------------------------------------------------------
module utf8_latin1_slug_transliterator_tb;
    import slug_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       eos;
        logic       run_end;
    } slug_out_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
    } src_item_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB} rx_mode_t;

    class slug_scoreboard;
        slug_out_t   due_q[$];
        logic [7:0]  line_q[$];
        sym_code_t   hi_tbl[64];
        logic [7:0]  sep_char;
        logic [7:0]  lead_byte;
        bit          lead_held;
        bit          seen_text;
        bit          sep_owed;
        int unsigned errors;
        int unsigned bytes_in;
        int unsigned strings_in;
        int unsigned end_marks;

        function new();
            // Latin-1 0xC0..0xFF folded symbols
            hi_tbl = '{SYM_A, SYM_A, SYM_A, SYM_A, SYM_AE, SYM_A, SYM_AE, SYM_C,
                       SYM_E, SYM_E, SYM_E, SYM_E, SYM_I, SYM_I, SYM_I, SYM_I,
                       SYM_D, SYM_N, SYM_O, SYM_O, SYM_O, SYM_O, SYM_OE, SYM_X,
                       SYM_NONE, SYM_U, SYM_U, SYM_U, SYM_UE, SYM_Y, SYM_P, SYM_SS,
                       SYM_A, SYM_A, SYM_A, SYM_A, SYM_AE, SYM_A, SYM_AE, SYM_C,
                       SYM_E, SYM_E, SYM_E, SYM_E, SYM_I, SYM_I, SYM_I, SYM_I,
                       SYM_O, SYM_N, SYM_O, SYM_O, SYM_O, SYM_O, SYM_OE, SYM_NONE,
                       SYM_NONE, SYM_U, SYM_U, SYM_U, SYM_UE, SYM_Y, SYM_P, SYM_Y};
            sep_char  = SEP_RESET;
            lead_byte = 8'h00;
            lead_held = 1'b0;
            seen_text = 1'b0;
            sep_owed  = 1'b0;
            errors    = 0;
        endfunction

        function void set_separator(logic [7:0] v);
            sep_char = v;
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        task report(string msg);
            if (errors < 20)
                $display("ERROR: %0t %s", $time, msg);
            errors++;
        endtask

        function string sym_spelling(sym_code_t code);
            case (code)
                SYM_A:   return "a";
                SYM_E:   return "e";
                SYM_I:   return "i";
                SYM_O:   return "o";
                SYM_U:   return "u";
                SYM_N:   return "n";
                SYM_C:   return "c";
                SYM_P:   return "p";
                SYM_Y:   return "y";
                SYM_X:   return "x";
                SYM_R:   return "r";
                SYM_D:   return "d";
                SYM_SS:  return "ss";
                SYM_AE:  return "ae";
                SYM_OE:  return "oe";
                SYM_UE:  return "ue";
                default: return "";
            endcase
        endfunction

        function sym_code_t latin_sym(logic [7:0] b);
            if (b >= 8'hC0)
                return hi_tbl[b[5:0]];
            case (b)
                8'hA1:        return SYM_I;
                8'hA2, 8'hA9: return SYM_C;
                8'hA5:        return SYM_Y;
                8'hAE:        return SYM_R;
                8'hB5:        return SYM_U;
                default:      return SYM_NONE;
            endcase
        endfunction

        function sym_code_t utf8_sym(logic [7:0] lead, logic [7:0] trail);
            if (lead == LEAD_C3) begin
                if (trail[7:6] != 2'b10)
                    return SYM_NONE;
                // O with stroke has no entry in the Latin-1 table
                if (trail == 8'h98 || trail == 8'hB8)
                    return SYM_O;
                return hi_tbl[trail[5:0]];
            end
            if (lead == LEAD_C2) begin
                case (trail)
                    8'hB5:        return SYM_U;
                    8'hA7, 8'hA2: return SYM_C;
                    8'hA5:        return SYM_Y;
                    8'hAE:        return SYM_R;
                    default:      return SYM_NONE;
                endcase
            end
            return SYM_NONE;
        endfunction

        // an owed separator only goes out in front of new content
        function void push_char(logic [7:0] c);
            if (sep_owed) begin
                line_q.push_back(sep_char);
                sep_owed = 1'b0;
            end
            line_q.push_back(c);
            seen_text = 1'b1;
        endfunction

        function void push_sym(sym_code_t code);
            string      spell;
            logic [7:0] c;
            int         i;
            spell = sym_spelling(code);
            for (i = 0; i < spell.len(); i++) begin
                c = spell[i];
                push_char(c);
            end
        endfunction

        function void fold_byte(logic [7:0] b);
            sym_code_t code;
            if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
                push_char(b);
            end
            else if (b >= "A" && b <= "Z") begin
                push_char(b | CASE_BIT);
            end
            else begin
                code = latin_sym(b);
                if (code != SYM_NONE)
                    push_sym(code);
                else if (seen_text)
                    sep_owed = 1'b1;
            end
        endfunction

        // predict the output characters caused by one accepted byte
        function void note_byte(logic [7:0] b, logic fin);
            sym_code_t code;
            bit        taken;
            slug_out_t r;
            int        k;
            line_q.delete();
            taken = 1'b0;
            bytes_in++;
            if (lead_held) begin
                code      = utf8_sym(lead_byte, b);
                lead_held = 1'b0;
                if (code != SYM_NONE) begin
                    push_sym(code);
                    taken = 1'b1;
                end
                else begin
                    fold_byte(lead_byte);
                end
            end
            if (!taken) begin
                if (!fin && (b == LEAD_C2 || b == LEAD_C3)) begin
                    lead_byte = b;
                    lead_held = 1'b1;
                end
                else begin
                    fold_byte(b);
                end
            end
            for (k = 0; k < line_q.size(); k++) begin
                r.ch       = line_q[k];
                r.has_char = 1'b1;
                r.run_end  = (k == line_q.size() - 1);
                r.eos      = fin && r.run_end;
                due_q.push_back(r);
            end
            if (fin) begin
                if (line_q.size() == 0) begin
                    r = '{ch: 8'h00, has_char: 1'b0, eos: 1'b1, run_end: 1'b1};
                    due_q.push_back(r);
                    end_marks++;
                end
                strings_in++;
                lead_held = 1'b0;
                lead_byte = 8'h00;
                seen_text = 1'b0;
                sep_owed  = 1'b0;
            end
        endfunction

        task check_char(logic [7:0] ch, logic hv, logic eos, logic re);
            slug_out_t want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected result byte=%02h valid=%0b end=%0b run_end=%0b",
                                 ch, hv, eos, re));
                return;
            end
            want = due_q.pop_front();
            if (ch !== want.ch || hv !== want.has_char || eos !== want.eos ||
                re !== want.run_end)
                report($sformatf({"got byte=%02h valid=%0b end=%0b run_end=%0b, ",
                                  "want %02h %0b %0b %0b"},
                                 ch, hv, eos, re, want.ch, want.has_char, want.eos,
                                 want.run_end));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_string;
    logic        last_of_run;

    slug_scoreboard sb;
    src_item_t      src_q[$];
    int             burst_left;
    int             hold_requests;
    int             holds_done;
    int             idle_cycles;
    int unsigned    out_xfers;
    int unsigned    seps_used;

    utf8_latin1_slug_transliterator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .last_of_run   (last_of_run)
    );

    always #1 clk = ~clk;

    function void push_src(logic [7:0] b);
        src_q.push_back('{b: b, fin: 1'b0});
    endfunction

    // bytes are listed first-to-last from the MSB end
    task add_string(input logic [8*12-1:0] packed_bytes, input int n);
        int i;
        for (i = 0; i < n; i++)
            push_src(packed_bytes[8*(n-1-i) +: 8]);
        src_q[src_q.size()-1].fin = 1'b1;
    endtask

    task add_random_string();
        int         n;
        int         r;
        logic [7:0] lead;
        n = $urandom_range(1, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                case ($urandom_range(0, 2))
                    0:       push_src(8'($urandom_range(8'h61, 8'h7A)));   // a..z
                    1:       push_src(8'($urandom_range(8'h41, 8'h5A)));   // A..Z
                    default: push_src(8'($urandom_range(8'h30, 8'h39)));   // 0..9
                endcase
            end
            else if (r < 52) begin
                // well-formed two-byte sequence, mostly mapped
                lead = $urandom_range(0, 1) ? LEAD_C3 : LEAD_C2;
                push_src(lead);
                if (lead == LEAD_C3) begin
                    push_src(8'($urandom_range(8'h80, 8'hBF)));
                end
                else begin
                    case ($urandom_range(0, 5))
                        0:       push_src(8'hB5);
                        1:       push_src(8'hA7);
                        2:       push_src(8'hA2);
                        3:       push_src(8'hA5);
                        4:       push_src(8'hAE);
                        default: push_src(8'($urandom_range(8'h80, 8'hBF)));
                    endcase
                end
            end
            else if (r < 64) begin
                push_src(8'($urandom_range(8'hA0, 8'hFF)));
            end
            else if (r < 80) begin
                case ($urandom_range(0, 4))
                    0:       push_src(8'h20);
                    1:       push_src(8'h2D);
                    2:       push_src(8'h2E);
                    3:       push_src(8'h5F);
                    default: push_src(8'h2C);
                endcase
            end
            else begin
                push_src(8'($urandom_range(0, 255)));
            end
        end
        src_q[src_q.size()-1].fin = 1'b1;
    endtask

    task fill_random(input int target);
        while (src_q.size() < target)
            add_random_string();
    endtask

    // sender: bursts of random length separated by random gaps
    task send_queue();
        src_item_t it;
        int        gap;
        while (src_q.size() > 0) begin
            it = src_q.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            in_valid  <= 1'b1;
            in_byte   <= it.b;
            last_byte <= it.fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sb.note_byte(it.b, it.fin);
        end
        in_valid <= 1'b0;
    endtask

    // a lead byte yields nothing until its follower, so pad past the last result
    task wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_separator(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_separator(v);
        seps_used++;
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge clk);
            tick++;
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       mode = RX_OPEN;
                        1:       mode = RX_COIN;
                        default: mode = RX_COMB;
                    endcase
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: out_ready <= 1'b1;
                    RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (tick % 3) != 0;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_char(out_byte, byte_valid, end_of_string, last_of_run);
            out_xfers++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending());
                $display("utf8_latin1_slug_transliterator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] sep_plan[$];
        int         p;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        burst_left    = 0;
        hold_requests = 0;
        holds_done    = 0;
        idle_cycles   = 0;
        out_xfers     = 0;
        seps_used     = 1;
        sb            = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading/trailing spaces, case fold, digits; trailing gap gives a bare end
        add_string(96'({8'h20, 8'h41, 8'h7A, 8'h30, 8'h39, 8'h5A, 8'h20, 8'h20}), 8);
        // mapped pairs: sharp s, A umlaut, micro, section, O stroke
        add_string(96'({8'hC3, 8'h9F, 8'hC3, 8'h84, 8'h2E, 8'hC2, 8'hB5, 8'hC2, 8'hA7,
                        8'hC3, 8'h98}), 11);
        // broken pairs, Latin-1 singles, lead byte that ends the string
        add_string(96'({8'hC3, 8'h41, 8'hC2, 8'h20, 8'hDF, 8'hA1, 8'hFF, 8'h00,
                        8'hC2}), 9);
        // nothing but a separator
        add_string(96'(8'h2E), 1);
        fill_random(70);
        send_queue();

        sep_plan = '{8'h00, 8'hFF, 8'h5F, 8'h78};
        sep_plan.push_back(8'($urandom_range(0, 255)));
        for (p = 0; p < sep_plan.size(); p++) begin
            write_separator(sep_plan[p]);
            // block fills and backs up the input while the sink holds off
            if (p == 1)
                hold_requests++;
            fill_random(50);
            send_queue();
        end

        wait_idle();
        $display("Covered %0d strings / %0d bytes, %0d output transfers (%0d bare end markers)",
                 sb.strings_in, sb.bytes_in, out_xfers, sb.end_marks);
        $display("Separator settings exercised: %0d, mismatches: %0d", seps_used, sb.errors);
        if (sb.errors == 0)
            $display("utf8_latin1_slug_transliterator: match");
        else
            $display("utf8_latin1_slug_transliterator: mismatch");
        $finish;
    end

endmodule
